// ===== rtl/core/mpsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsl_pkg - shared types and constants of the motor packet serial link
// Request layouts, opcodes, status codes, register indexes and the CRC step.
// ----------------------------------------------------------------------------
package mpsl_pkg;

  // Opcodes of an input request
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Report status codes
  localparam logic [2:0] ST_ACKED     = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_READ_OK   = 3'd2;
  localparam logic [2:0] ST_CRC_BAD   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_BUSY      = 3'd5;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_RETRIES   = 2'd0;
  localparam logic [1:0] CFG_ACK_BYTE      = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam int unsigned CfgDataW = 16;

  localparam logic [2:0]  RETRIES_RST = 3'd3;
  localparam logic [7:0]  ACK_RST     = 8'hFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  SAT_CODE  = 8'd12;
  localparam logic [7:0]  SAT_LIMIT = 8'd127;

  // Response is four data bytes and two CRC bytes
  localparam logic [2:0] RESP_DATA_BYTES = 3'd4;
  localparam logic [2:0] RESP_BYTES      = 3'd6;

  localparam int unsigned BurstLen = 5;
  localparam int unsigned BurstCntW = $clog2(BurstLen + 1);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] address;
    logic [7:0] command_code;
    logic [7:0] value;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic [2:0]         status;
    logic signed [31:0] read_value;
  } out_req_t;

  typedef struct packed {
    logic [2:0]  max_retries;
    logic [7:0]  ack_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Result group of one request: a run of transmit bytes or a single report
  typedef struct packed {
    logic [BurstCntW-1:0]      count;
    logic                      is_report;
    logic [BurstLen-1:0][7:0]  bytes;
    logic [2:0]                status;
    logic signed [31:0]        read_value;
  } burst_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mpsl_engine.sv =====
// ----------------------------------------------------------------------------
// mpsl_engine - request register and transaction state
// Registers one request, then decodes it against the link state in one pass.
// ----------------------------------------------------------------------------
module mpsl_engine import mpsl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_data_i,
  input  logic    burst_ready_i,
  output logic    burst_load_o,
  output burst_t  burst_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WRITE = 3'b010,
    PH_READ  = 3'b100
  } phase_e;

  logic    in_vld_q, in_vld_d;
  in_req_t in_q;
  logic    fire;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  tries_q, tries_d;
  logic [23:0] saved_q, saved_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [47:0] shift_q, shift_d;
  logic [15:0] ticks_q, ticks_d;

  logic        is_write;
  logic [7:0]  sat_val;
  logic [23:0] pkt;
  logic [15:0] pkt_crc;
  logic [15:0] crc_rx;
  logic [2:0]  cnt_n;
  logic [47:0] shift_n;
  logic [15:0] ticks_n;

  assign in_stall_o = in_vld_q && !burst_ready_i;
  assign fire       = in_vld_q && burst_ready_i;
  assign in_vld_d   = in_stall_o ? in_vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Packet send path: one CRC chain shared by a new write and a resend
  assign is_write = in_q.opcode == OP_WRITE;
  assign sat_val  = (in_q.command_code == SAT_CODE && in_q.value > SAT_LIMIT) ?
                    SAT_LIMIT : in_q.value;
  assign pkt      = is_write ? {in_q.address, in_q.command_code, sat_val} : saved_q;
  assign pkt_crc  = crc_byte(crc_byte(crc_byte(16'h0000, pkt[23:16]), pkt[15:8]), pkt[7:0]);

  assign crc_rx  = (cnt_q < RESP_DATA_BYTES) ? crc_byte(crc_q, in_q.rx_byte) : crc_q;
  assign cnt_n   = cnt_q + 3'd1;
  assign shift_n = {shift_q[39:0], in_q.rx_byte};
  assign ticks_n = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    tries_d = tries_q;
    saved_d = saved_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    ticks_d = ticks_q;

    burst_o            = '0;
    burst_o.read_value = '0;

    unique case (in_q.opcode)
      OP_WRITE, OP_READ: begin
        if (phase_q != PH_IDLE) begin
          burst_o.count     = BurstCntW'(1);
          burst_o.is_report = 1'b1;
          burst_o.status    = ST_BUSY;
        end else if (is_write) begin
          saved_d = pkt;
          tries_d = cfg_i.max_retries;
          phase_d = PH_WRITE;
          ticks_d = '0;
          crc_d   = pkt_crc;
          burst_o.count = BurstCntW'(5);
          burst_o.bytes = {pkt_crc[7:0], pkt_crc[15:8], pkt[7:0], pkt[15:8], pkt[23:16]};
        end else begin
          crc_d   = crc_byte(crc_byte(16'h0000, in_q.address), in_q.command_code);
          cnt_d   = '0;
          shift_d = '0;
          ticks_d = '0;
          phase_d = PH_READ;
          burst_o.count       = BurstCntW'(2);
          burst_o.bytes[0]    = in_q.address;
          burst_o.bytes[1]    = in_q.command_code;
        end
      end
      OP_RX: begin
        unique case (phase_q)
          PH_WRITE: begin
            if (in_q.rx_byte == cfg_i.ack_byte) begin
              phase_d           = PH_IDLE;
              burst_o.count     = BurstCntW'(1);
              burst_o.is_report = 1'b1;
              burst_o.status    = ST_ACKED;
            end else if (tries_q != 3'd0) begin
              tries_d = tries_q - 3'd1;
              ticks_d = '0;
              crc_d   = pkt_crc;
              burst_o.count = BurstCntW'(5);
              burst_o.bytes = {pkt_crc[7:0], pkt_crc[15:8], pkt[7:0], pkt[15:8],
                               pkt[23:16]};
            end else begin
              phase_d           = PH_IDLE;
              burst_o.count     = BurstCntW'(1);
              burst_o.is_report = 1'b1;
              burst_o.status    = ST_EXHAUSTED;
            end
          end
          PH_READ: begin
            ticks_d = '0;
            crc_d   = crc_rx;
            shift_d = shift_n;
            cnt_d   = cnt_n;
            if (cnt_n >= RESP_BYTES) begin
              phase_d              = PH_IDLE;
              cnt_d                = '0;
              burst_o.count        = BurstCntW'(1);
              burst_o.is_report    = 1'b1;
              burst_o.status       = (shift_n[15:0] == crc_rx) ? ST_READ_OK : ST_CRC_BAD;
              burst_o.read_value   = shift_n[47:16];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        // time tick
        if (phase_q != PH_IDLE) begin
          ticks_d = ticks_n;
          if (ticks_n >= cfg_i.timeout_ticks) begin
            phase_d           = PH_IDLE;
            ticks_d           = '0;
            cnt_d             = '0;
            burst_o.count     = BurstCntW'(1);
            burst_o.is_report = 1'b1;
            burst_o.status    = ST_TIMEOUT;
          end
        end
      end
    endcase
  end

  assign burst_load_o = fire && (burst_o.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= '0;
      tries_q <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      ticks_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      tries_q <= tries_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      ticks_q <= ticks_d;
    end
  end

  // only read while a write is pending, so no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      saved_q <= saved_d;
    end
  end

endmodule

// ===== rtl/core/mpsl_burst.sv =====
// ----------------------------------------------------------------------------
// mpsl_burst - result register
// Holds the result group of one request; hands out one per unstalled cycle.
// ----------------------------------------------------------------------------
module mpsl_burst import mpsl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  burst_t   burst_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_data_o
);

  logic [BurstCntW-1:0]     cnt_q, cnt_d;
  logic                     rep_q;
  logic [BurstLen-1:0][7:0] bytes_q;
  logic [2:0]               status_q;
  logic signed [31:0]       rv_q;
  logic                     pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign ready_o     = (cnt_q == '0) || (pop && cnt_q == BurstCntW'(1));

  always_comb begin
    if (load_i) begin
      cnt_d = burst_i.count;
    end else if (pop) begin
      cnt_d = cnt_q - BurstCntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rep_q    <= burst_i.is_report;
      bytes_q  <= burst_i.bytes;
      status_q <= burst_i.status;
      rv_q     <= burst_i.read_value;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[BurstLen-1:1]};
    end
  end

  always_comb begin
    if (rep_q) begin
      out_data_o.kind       = KIND_REPORT;
      out_data_o.tx_byte    = '0;
      out_data_o.last       = 1'b1;
      out_data_o.status     = status_q;
      out_data_o.read_value = rv_q;
    end else begin
      out_data_o.kind       = KIND_TX;
      out_data_o.tx_byte    = bytes_q[0];
      out_data_o.last       = cnt_q == BurstCntW'(1);
      out_data_o.status     = '0;
      out_data_o.read_value = '0;
    end
  end

endmodule

// ===== rtl/core/motor_packet_serial_link.sv =====
// ----------------------------------------------------------------------------
// motor_packet_serial_link - host side of a packet serial motor link
// Builds write and read packets with CRC-16, tracks acknowledge, retries,
// read responses and timeouts, and emits transmit bytes and reports.
// ----------------------------------------------------------------------------
// Usage: each input request is one event (write command, read command,
// received byte or time tick). A request sits in the input register, is
// decoded there against the link state, and its results land in the result
// register, which emits one result per cycle while out_stall_i is low, from
// the following cycle on. A write (or a resend) gives five transmit bytes, a
// read command two, a report one, and ignored bytes and ticks none. The
// input is taken again as soon as the result register is down to its last
// pending result, so back-to-back events flow at one per cycle whenever they
// produce at most one result each and the output is not stalled. The output
// register count sets the sustained rate. Configuration registers (max
// retries, acknowledge byte, timeout ticks) are written through cfg_we_i /
// cfg_index_i / cfg_wdata_i and should change only while the link is idle.
// ----------------------------------------------------------------------------
module motor_packet_serial_link import mpsl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_req_t            out_data_o
);

  cfg_t   cfg_q;
  logic   burst_ready;
  logic   burst_load;
  burst_t burst;

  // Configuration registers; index 3 is unused and dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries   <= RETRIES_RST;
      cfg_q.ack_byte      <= ACK_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_RETRIES:   cfg_q.max_retries   <= cfg_wdata_i[2:0];
        CFG_ACK_BYTE:      cfg_q.ack_byte      <= cfg_wdata_i[7:0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Request decode and link state
  mpsl_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .burst_ready_i (burst_ready),
    .burst_load_o  (burst_load),
    .burst_o       (burst)
  );

  // Result register, one result per cycle while out_stall_i is low
  mpsl_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (burst_load),
    .burst_i     (burst),
    .ready_o     (burst_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
